// ===== hw/rtl/dda_line_pixel_stepper_unit_defines.svh =====
// Assertion macros used by the line stepper controller.
`ifndef DDA_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH
`define DDA_LINE_PIXEL_STEPPER_UNIT_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define DLPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold on the clock edge after a trigger.
`define DLPS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dlps_pkg.sv =====
// Shared types and constants of the line pixel stepper.
package dlps_pkg;

  localparam int COORD_W   = 24;
  localparam int DELTA_W   = 25;
  localparam int PIX_W     = 12;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 1'b1;

  localparam int CFG_RESET = 1024;

  localparam int SCALE_FACTOR_DEF = 4;
  localparam int MAX_STEPS_DEF    = 64;
  localparam int FRAC_BITS_DEF    = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic setup;
    logic div_step;
    logic issue;
  } dlps_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic zero_len;
    logic last;
    logic pipe_adv;
  } dlps_sts_t;

endpackage

// ===== hw/rtl/dlps_if.sv =====
// Valid/ready channel interfaces for line requests and pixel results.
interface dlps_in_if;
  import dlps_pkg::*;
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  input ready);
  modport sink   (input valid, input start_x, input start_y, input end_x, input end_y,
                  output ready);
endinterface

interface dlps_out_if;
  import dlps_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_x;
  logic [PIX_W-1:0] pixel_y;
  logic             visible;
  logic             last_point;
  logic             truncated;

  modport source (output valid, output pixel_x, output pixel_y, output visible,
                  output last_point, output truncated, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input visible,
                  input last_point, input truncated, output ready);
endinterface

// ===== hw/rtl/dlps_ctrl.sv =====
// Controller state machine of the line pixel stepper.
`include "dda_line_pixel_stepper_unit_defines.svh"

module dlps_ctrl #(
  parameter int FRAC_BITS = dlps_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dlps_pkg::dlps_sts_t sts,
  output dlps_pkg::dlps_cmd_t cmd
);
  import dlps_pkg::*;

  localparam int DIV_CNT_W = $clog2(FRAC_BITS + 2);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SETUP = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t               state_r, state_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;

  always_comb begin
    state_nxt   = state_r;
    div_cnt_nxt = div_cnt_r;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd.setup   = 1'b1;
        div_cnt_nxt = '0;
        state_nxt   = sts.zero_len ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(FRAC_BITS)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.pipe_adv) begin
          cmd.issue = 1'b1;
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      div_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      div_cnt_r <= div_cnt_nxt;
    end
  end

  `DLPS_ASSERT(a_issue_needs_room, cmd.issue |-> sts.pipe_adv, "point issued into a full pipe")
  `DLPS_ASSERT_NEXT(a_load_to_setup, cmd.load, state_r == ST_SETUP, "load not followed by setup")
  `DLPS_ASSERT_NEXT(a_last_to_idle, cmd.issue && sts.last, state_r == ST_IDLE,
                    "walk did not end after last point")
  `DLPS_ASSERT(a_ready_no_work, in_ready |-> !cmd.div_step && !cmd.issue,
               "ready raised while a line is in progress")

endmodule

// ===== hw/rtl/dlps_dp.sv =====
// Datapath: deltas, increment divider, point stepper and pixel pipeline.
module dlps_dp #(
  parameter int SCALE_FACTOR = dlps_pkg::SCALE_FACTOR_DEF,
  parameter int MAX_STEPS    = dlps_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS    = dlps_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dlps_pkg::dlps_cmd_t               cmd,
  output dlps_pkg::dlps_sts_t               sts,
  input  logic [dlps_pkg::COORD_W-1:0]      start_x,
  input  logic [dlps_pkg::COORD_W-1:0]      start_y,
  input  logic [dlps_pkg::COORD_W-1:0]      end_x,
  input  logic [dlps_pkg::COORD_W-1:0]      end_y,
  input  logic                              cfg_we,
  input  logic [dlps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dlps_pkg::CFG_W-1:0]        cfg_data,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [dlps_pkg::PIX_W-1:0]        pixel_x,
  output logic [dlps_pkg::PIX_W-1:0]        pixel_y,
  output logic                              visible,
  output logic                              last_point,
  output logic                              truncated
);
  import dlps_pkg::*;

  localparam int REM_W = DELTA_W + 1;
  localparam int QW    = FRAC_BITS + 1;
  localparam int CNT_W = $clog2(MAX_STEPS + 1);
  localparam int BND_W = CFG_W + $clog2(SCALE_FACTOR + 1) + FRAC_BITS;
  localparam logic [BND_W-1:0] BND_RST =
    BND_W'(CFG_RESET * SCALE_FACTOR * (1 << FRAC_BITS));
  localparam int RCP_W = COORD_W + 1;
  localparam int PRD_W = COORD_W + RCP_W;
  localparam int QS_W  = COORD_W + 7;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'((1 << COORD_W) / SCALE_FACTOR);

  // Line registers.
  logic [COORD_W-1:0]        cur_x_r, cur_y_r;
  logic signed [DELTA_W-1:0] dx_r, dy_r;
  logic                      sgn_x_r, sgn_y_r;
  logic [DELTA_W-1:0]        step_r;
  logic [REM_W-1:0]          rem_x_r, rem_y_r;
  logic [QW-1:0]             q_x_r, q_y_r;
  logic [CNT_W-1:0]          steps_left_r;
  logic                      sat_r;
  logic [BND_W-1:0]          bound_w_r, bound_h_r;

  // First pixel stage.
  logic               s1_valid_r;
  logic               s1_neg_x_r, s1_neg_y_r;
  logic [COORD_W-1:0] s1_m_x_r, s1_m_y_r;
  logic [COORD_W-1:0] s1_q0_x_r, s1_q0_y_r;
  logic               s1_vis_r, s1_last_r, s1_trunc_r;

  // Output stage.
  logic             out_valid_r;
  logic [PIX_W-1:0] pix_x_r, pix_y_r;
  logic             vis_r, last_r, trunc_r;

  logic [DELTA_W-1:0] mag_x, mag_y, step_nxt;
  logic [REM_W:0]     trial_x, trial_y;
  logic               bit_x, bit_y;
  logic [REM_W-1:0]   keep_x, keep_y;
  logic [REM_W-1:0]   cnt_sum, cnt_full;
  logic               sat_nxt;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               adv, pt_last;

  function automatic logic [COORD_W-1:0] pix_mag(input logic [COORD_W-1:0] p);
    logic [COORD_W-1:0] a;
    a = p[COORD_W-1] ? (~p + COORD_W'(1)) : p;
    return a >> FRAC_BITS;
  endfunction

  function automatic logic [COORD_W-1:0] recip_quot(input logic [COORD_W-1:0] m);
    logic [PRD_W-1:0] prod;
    prod = PRD_W'(m) * PRD_W'(RECIP);
    return prod[2*COORD_W-1:COORD_W];
  endfunction

  function automatic logic [PIX_W-1:0] pix_fix(input logic [COORD_W-1:0] q0,
                                               input logic [COORD_W-1:0] m,
                                               input logic neg);
    logic [QS_W-1:0]  qs;
    logic [QS_W-1:0]  r;
    logic [PIX_W-1:0] ql;
    qs = QS_W'(q0) * QS_W'(SCALE_FACTOR);
    r  = QS_W'(m) - qs;
    ql = q0[PIX_W-1:0] + PIX_W'(r >= QS_W'(SCALE_FACTOR));
    return neg ? (~ql + PIX_W'(1)) : ql;
  endfunction

  // Magnitudes, step length and point count.
  always_comb begin
    mag_x    = dx_r[DELTA_W-1] ? DELTA_W'(-dx_r) : DELTA_W'(dx_r);
    mag_y    = dy_r[DELTA_W-1] ? DELTA_W'(-dy_r) : DELTA_W'(dy_r);
    step_nxt = (mag_x > mag_y) ? mag_x : mag_y;
    cnt_sum  = REM_W'(step_r) + REM_W'((1 << FRAC_BITS) - 1);
    cnt_full = cnt_sum >> FRAC_BITS;
    sat_nxt  = cnt_full > REM_W'(MAX_STEPS);
    cnt_nxt  = sat_nxt ? CNT_W'(MAX_STEPS) : cnt_full[CNT_W-1:0];
  end

  // One restoring division step per lane.
  always_comb begin
    trial_x = {1'b0, rem_x_r} - (REM_W + 1)'(step_r);
    trial_y = {1'b0, rem_y_r} - (REM_W + 1)'(step_r);
    bit_x   = !trial_x[REM_W];
    bit_y   = !trial_y[REM_W];
    keep_x  = bit_x ? trial_x[REM_W-1:0] : rem_x_r;
    keep_y  = bit_y ? trial_y[REM_W-1:0] : rem_y_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_x_r <= start_x;
      cur_y_r <= start_y;
      dx_r    <= DELTA_W'($signed(end_x)) - DELTA_W'($signed(start_x));
      dy_r    <= DELTA_W'($signed(end_y)) - DELTA_W'($signed(start_y));
    end else if (cmd.issue) begin
      cur_x_r <= sgn_x_r ? cur_x_r - COORD_W'(q_x_r) : cur_x_r + COORD_W'(q_x_r);
      cur_y_r <= sgn_y_r ? cur_y_r - COORD_W'(q_y_r) : cur_y_r + COORD_W'(q_y_r);
    end
    if (cmd.setup) begin
      sgn_x_r <= dx_r[DELTA_W-1];
      sgn_y_r <= dy_r[DELTA_W-1];
      step_r  <= step_nxt;
      rem_x_r <= REM_W'(mag_x);
      rem_y_r <= REM_W'(mag_y);
    end else if (cmd.div_step) begin
      rem_x_r <= keep_x << 1;
      rem_y_r <= keep_y << 1;
      q_x_r   <= QW'({q_x_r, bit_x});
      q_y_r   <= QW'({q_y_r, bit_y});
      sat_r   <= sat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_left_r <= '0;
    end else if (cmd.div_step) begin
      steps_left_r <= cnt_nxt;
    end else if (cmd.issue) begin
      steps_left_r <= steps_left_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bound_w_r <= BND_RST;
      bound_h_r <= BND_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  bound_w_r <= (BND_W'(cfg_data) * BND_W'(SCALE_FACTOR)) << FRAC_BITS;
        CFG_IMAGE_HEIGHT: bound_h_r <= (BND_W'(cfg_data) * BND_W'(SCALE_FACTOR)) << FRAC_BITS;
        default: ;
      endcase
    end
  end

  // Pixel pipeline; both stages move together when the output slot frees.
  assign adv     = !out_valid_r || out_ready;
  assign pt_last = steps_left_r == CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r  <= cmd.issue;
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_neg_x_r <= cur_x_r[COORD_W-1];
      s1_neg_y_r <= cur_y_r[COORD_W-1];
      s1_m_x_r   <= pix_mag(cur_x_r);
      s1_m_y_r   <= pix_mag(cur_y_r);
      s1_q0_x_r  <= recip_quot(pix_mag(cur_x_r));
      s1_q0_y_r  <= recip_quot(pix_mag(cur_y_r));
      s1_vis_r   <= !cur_x_r[COORD_W-1] && !cur_y_r[COORD_W-1] &&
                    (32'(cur_x_r[COORD_W-2:0]) < 32'(bound_w_r)) &&
                    (32'(cur_y_r[COORD_W-2:0]) < 32'(bound_h_r));
      s1_last_r  <= pt_last;
      s1_trunc_r <= pt_last && sat_r;
      pix_x_r    <= pix_fix(s1_q0_x_r, s1_m_x_r, s1_neg_x_r);
      pix_y_r    <= pix_fix(s1_q0_y_r, s1_m_y_r, s1_neg_y_r);
      vis_r      <= s1_vis_r;
      last_r     <= s1_last_r;
      trunc_r    <= s1_trunc_r;
    end
  end

  assign sts.zero_len = (dx_r == '0) && (dy_r == '0);
  assign sts.last     = pt_last;
  assign sts.pipe_adv = adv;

  assign out_valid  = out_valid_r;
  assign pixel_x    = pix_x_r;
  assign pixel_y    = pix_y_r;
  assign visible    = vis_r;
  assign last_point = last_r;
  assign truncated  = trunc_r;

endmodule

// ===== hw/rtl/dda_line_pixel_stepper_unit.sv =====
// Top level of the DDA line pixel stepper.
//
// The in_ch channel takes one line request per transfer: start and end points
// in signed fixed point with FRAC_BITS fraction bits. The block walks the line
// with the DDA scheme and sends one transfer per point on out_ch: the pixel
// coordinate (point divided by SCALE_FACTOR, rounded toward zero), a visible
// flag from clipping against image_width and image_height, a last_point
// marker, and a truncated flag on the last point when the point count was
// capped at MAX_STEPS. A zero-length line produces no transfers.
// After a request transfer the block registers the deltas, then the step length
// in its setup state, then runs a restoring divider that forms both increments
// bit by bit, FRAC_BITS + 1 quotient bits each. It then issues one point per
// cycle, as long as out_ch does not stall, into a two-stage pixel pipeline of a
// first pixel stage and an output stage. The next request is taken once the
// last point has been issued, while the final points still drain.
// When out_ch stalls the pipeline holds and no further points are issued; no
// result is dropped. Synchronous reset clears all control state and restores
// both image registers to 1024; configuration writes belong to idle periods.
module dda_line_pixel_stepper_unit #(
  parameter int SCALE_FACTOR = dlps_pkg::SCALE_FACTOR_DEF,
  parameter int MAX_STEPS    = dlps_pkg::MAX_STEPS_DEF,
  parameter int FRAC_BITS    = dlps_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  dlps_in_if.sink                        in_ch,
  dlps_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [dlps_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dlps_pkg::CFG_W-1:0]     cfg_data
);
  import dlps_pkg::*;

  dlps_cmd_t cmd;
  dlps_sts_t sts;

  // The controller sequences setup, division and point issue.
  dlps_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds the line state, the divider and the pixel pipeline.
  dlps_dp #(
    .SCALE_FACTOR (SCALE_FACTOR),
    .MAX_STEPS    (MAX_STEPS),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .start_x    (in_ch.start_x),
    .start_y    (in_ch.start_y),
    .end_x      (in_ch.end_x),
    .end_y      (in_ch.end_y),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .pixel_x    (out_ch.pixel_x),
    .pixel_y    (out_ch.pixel_y),
    .visible    (out_ch.visible),
    .last_point (out_ch.last_point),
    .truncated  (out_ch.truncated)
  );

endmodule

// ===== dv/dda_line_pixel_stepper_unit_tb.sv =====
// Self-checking testbench for the DDA line pixel stepper, with its own line walker.
`timescale 1ns / 1ps

module dda_line_pixel_stepper_unit_tb;
  import dlps_pkg::*;

  // The block runs with its default parameters, so the walker uses the same values.
  localparam int     SCALE       = SCALE_FACTOR_DEF;
  localparam int     MAX_PTS     = MAX_STEPS_DEF;
  localparam int     FRAC        = FRAC_BITS_DEF;
  localparam longint ONE         = longint'(1) << FRAC;
  // World units covered by one pixel.
  localparam longint PIX_SPAN    = ONE * SCALE;
  // Idle time allowed for a zero-length request or the last points that still drain.
  localparam int     SETTLE      = 2 * (FRAC + 5) + 16;
  // Longest quiet stretch of a correct run is a phase change, well under this.
  localparam int     QUIET_LIMIT = 2000;
  localparam int     MAX_REPORTS = 30;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_x;
    logic [PIX_W-1:0] pixel_y;
    logic             visible;
    logic             last_point;
    logic             truncated;
  } pixel_res_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  dlps_in_if  in_if ();
  dlps_out_if out_if ();

  dda_line_pixel_stepper_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Line requests waiting to be driven, and pixels the walker expects, oldest first.
  line_req_t  line_q[$];
  pixel_res_t pixel_exp_q[$];

  // Shadow copies of the image registers, as the block should hold them.
  logic [CFG_W-1:0] img_w = CFG_W'(CFG_RESET);
  logic [CFG_W-1:0] img_h = CFG_W'(CFG_RESET);

  // Idle control: chance in percent of starting an idle burst on each side.
  int gap_pct   = 0;
  int stall_pct = 0;
  int gap_left   = 0;
  int stall_left = 0;

  int lines_queued  = 0;
  int lines_taken   = 0;
  int pixels_seen   = 0;
  int capped_lines  = 0;
  int zero_lines    = 0;
  int settings_seen = 1;
  int fails         = 0;
  int quiet_cycles  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Walk one line request the way the block should and queue the pixels it yields.
  // Increments are the deltas scaled by ONE and divided by the step length, rounded
  // toward zero; the walk wraps at the coordinate width, like the block's registers.
  task automatic expand_line(input line_req_t r);
    longint sx, sy, dx, dy, mx, my, step, count, px, py, bound_x, bound_y;
    logic [COORD_W-1:0] cx, cy, ix, iy;
    logic capped;
    pixel_res_t p;
    sx = longint'(signed'(r.start_x));
    sy = longint'(signed'(r.start_y));
    dx = longint'(signed'(r.end_x)) - sx;
    dy = longint'(signed'(r.end_y)) - sy;
    mx = (dx < 0) ? -dx : dx;
    my = (dy < 0) ? -dy : dy;
    step = (mx > my) ? mx : my;
    if (step == 0) begin
      // A zero-length line yields no pixels at all.
      zero_lines++;
      return;
    end
    count  = (step + ONE - 1) >> FRAC;
    capped = (count > MAX_PTS);
    if (capped) begin
      count = MAX_PTS;
      capped_lines++;
    end
    cx = r.start_x;
    cy = r.start_y;
    ix = COORD_W'((dx * ONE) / step);
    iy = COORD_W'((dy * ONE) / step);
    bound_x = longint'(img_w) * PIX_SPAN;
    bound_y = longint'(img_h) * PIX_SPAN;
    for (longint k = count; k > 0; k--) begin
      px = longint'(signed'(cx));
      py = longint'(signed'(cy));
      // Division of signed values truncates toward zero, so pixels left of or above
      // the image still carry their quotient in two's complement.
      p.pixel_x    = PIX_W'(px / PIX_SPAN);
      p.pixel_y    = PIX_W'(py / PIX_SPAN);
      p.visible    = (px >= 0) && (px < bound_x) && (py >= 0) && (py < bound_y);
      p.last_point = (k == 1);
      p.truncated  = (k == 1) && capped;
      pixel_exp_q.push_back(p);
      cx = cx + ix;
      cy = cy + iy;
    end
  endtask

  function automatic line_req_t make_line(input longint sx, input longint sy,
                                          input longint ex, input longint ey);
    line_req_t r;
    r.start_x = COORD_W'(sx);
    r.start_y = COORD_W'(sy);
    r.end_x   = COORD_W'(ex);
    r.end_y   = COORD_W'(ey);
    return r;
  endfunction

  // Random line around the image. Reach is the image extent in world units.
  // Most lines walk up to the point cap, some sit right at the cap, some are
  // zero or near-zero length, and some are raw random words that cover every bit.
  function automatic line_req_t random_line(input longint reach);
    longint sx, sy, ex, ey, len, minor;
    int pick;
    line_req_t r;
    pick = $urandom_range(99);
    if (pick < 12) begin
      r.start_x = COORD_W'($urandom);
      r.start_y = COORD_W'($urandom);
      r.end_x   = COORD_W'($urandom);
      r.end_y   = COORD_W'($urandom);
      return r;
    end
    sx = longint'($urandom_range(0, int'(reach + reach / 4))) - reach / 8;
    sy = longint'($urandom_range(0, int'(reach + reach / 4))) - reach / 8;
    if (pick < 20) begin
      ex = sx + longint'($urandom_range(0, 2)) - 1;
      ey = sy + longint'($urandom_range(0, 2)) - 1;
    end else begin
      if (pick < 32)
        len = MAX_PTS * ONE - 300 + longint'($urandom_range(0, 600));
      else
        len = longint'($urandom_range(1, int'(MAX_PTS * ONE)));
      minor = longint'($urandom_range(0, int'(len)));
      if ($urandom_range(1)) len = -len;
      if ($urandom_range(1)) minor = -minor;
      if ($urandom_range(1)) begin
        ex = sx + len;
        ey = sy + minor;
      end else begin
        ex = sx + minor;
        ey = sy + len;
      end
    end
    return make_line(sx, sy, ex, ey);
  endfunction

  task automatic queue_line(input line_req_t r);
    line_q.push_back(r);
    lines_queued++;
  endtask

  // Block until every queued line has been taken and every pixel has come back,
  // then give the block time to finish any work that yields no pixel.
  task automatic wait_idle();
    while (!(lines_taken == lines_queued && pixel_exp_q.size() == 0))
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_IMAGE_WIDTH)
      img_w = val;
    else
      img_h = val;
  endtask

  // One phase: wait for the block to go quiet, set the image size and idle rates,
  // then queue a batch of random lines scaled to the image.
  task automatic run_phase(input int n, input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                           input int gap, input int stall);
    longint reach;
    wait_idle();
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    settings_seen++;
    gap_pct   = gap;
    stall_pct = stall;
    reach = longint'((w > h) ? w : h) * PIX_SPAN;
    if (reach < 8 * PIX_SPAN) reach = 8 * PIX_SPAN;
    if (reach > 4000000) reach = 4000000;
    repeat (n) queue_line(random_line(reach));
  endtask

  // Request driver. A request stays on the channel until its transfer; the walker
  // runs at the transfer edge, so it always sees the image size in force then.
  always @(posedge clk) begin : line_driver
    logic show;
    line_req_t nxt;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expand_line({in_if.start_x, in_if.start_y, in_if.end_x, in_if.end_y});
        lines_taken++;
      end
      // Hold a request that has not been taken yet; otherwise pick what comes next.
      if (!(in_if.valid && !in_if.ready)) begin
        show = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (line_q.size() > 0) begin
          if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            // This cycle is the first of the burst.
            gap_left = $urandom_range(1, 4) - 1;
          end else begin
            nxt = line_q.pop_front();
            show = 1'b1;
            in_if.start_x <= nxt.start_x;
            in_if.start_y <= nxt.start_y;
            in_if.end_x   <= nxt.end_x;
            in_if.end_y   <= nxt.end_y;
          end
        end
        in_if.valid <= show;
      end
    end
  end

  task automatic check_field(input string what, input logic [PIX_W-1:0] want,
                             input logic [PIX_W-1:0] got);
    if (want !== got) begin
      fails++;
      if (fails <= MAX_REPORTS)
        $display("%0t: %s mismatch on pixel %0d, expected %0h, actual %0h",
                 $time, what, pixels_seen, want, got);
    end
  endtask

  // Pixel monitor. Each pixel transfer is checked against the oldest expected pixel,
  // and ready drops in random bursts so that stalls land on every pipeline phase.
  always @(posedge clk) begin : pixel_monitor
    pixel_res_t got, want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        got = {out_if.pixel_x, out_if.pixel_y, out_if.visible, out_if.last_point,
               out_if.truncated};
        pixels_seen++;
        if (pixel_exp_q.size() == 0) begin
          fails++;
          if (fails <= MAX_REPORTS)
            $display("%0t: pixel (%0h, %0h) with no point expected, expected none, actual %0h",
                     $time, got.pixel_x, got.pixel_y, got);
        end else begin
          want = pixel_exp_q.pop_front();
          check_field("pixel_x",    want.pixel_x,    got.pixel_x);
          check_field("pixel_y",    want.pixel_y,    got.pixel_y);
          check_field("visible",    PIX_W'(want.visible),    PIX_W'(got.visible));
          check_field("last_point", PIX_W'(want.last_point), PIX_W'(got.last_point));
          check_field("truncated",  PIX_W'(want.truncated),  PIX_W'(got.truncated));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(1, 4) - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog: a correct block never stays this long without a transfer or a write.
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: no transfer for %0d cycles, %0d pixels still expected",
               $time, quiet_cycles, pixel_exp_q.size());
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_IMAGE_WIDTH;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.start_x = '0;
    in_if.start_y = '0;
    in_if.end_x   = '0;
    in_if.end_y   = '0;
    out_if.ready  = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed lines under the reset image size of 1024 by 1024 pixels.
    gap_pct   = 20;
    stall_pct = 20;
    // Zero-length lines, at the origin and at the top of the coordinate range.
    queue_line(make_line(0, 0, 0, 0));
    queue_line(make_line(8388607, 8388607, 8388607, 8388607));
    // One-point lines, forward and backward, and two across the minus-one boundary.
    queue_line(make_line(0, 0, 1, 0));
    queue_line(make_line(256, 256, 0, 0));
    queue_line(make_line(0, 0, -1, 0));
    queue_line(make_line(-1, -1, 0, 0));
    // Exactly the point cap, then one unit past it so the count saturates.
    queue_line(make_line(0, 0, MAX_PTS * ONE, 0));
    queue_line(make_line(0, 0, MAX_PTS * ONE + 1, 0));
    // Full-range diagonals in both directions.
    queue_line(make_line(-8388608, -8388608, 8388607, 8388607));
    queue_line(make_line(8388607, -8388608, -8388608, 8388607));
    // Vertical line at a negative x, so no point is visible.
    queue_line(make_line(-2048, 5000, -2048, -9000));
    // Lines that cross the image at its right and bottom edges.
    queue_line(make_line(1024 * PIX_SPAN - 3000, 512 * PIX_SPAN,
                         1024 * PIX_SPAN + 3000, 512 * PIX_SPAN));
    queue_line(make_line(300 * PIX_SPAN, 1024 * PIX_SPAN + 2500,
                         300 * PIX_SPAN, 1024 * PIX_SPAN - 2500));
    // Crossing zero: small negative points round toward zero but stay hidden.
    queue_line(make_line(-3000, 700, 3000, -700));
    // Diagonal, steep and shallow lines; all but the diagonal have fractional increments.
    queue_line(make_line(1000, 1000, 1000 + 40 * ONE, 1000 + 40 * ONE));
    queue_line(make_line(5000, 9000, 5000 + 333, 9000 - 50 * ONE));
    queue_line(make_line(100, 100, 400, 177));
    queue_line(make_line(-7 * ONE, -3 * ONE, -30 * ONE, -45 * ONE));
    // Alternating bit patterns in every field, then a line of long runs of ones and zeros.
    queue_line(make_line(24'h555555, 24'hAAAAAA, 24'hAAAAAA, 24'h555555));
    queue_line(make_line(24'h7FFF00, 24'h0000FF, 24'h7FE000, 24'h001000));

    // Smallest image: only the very first pixel is visible. Output side stalls hard.
    run_phase(30, 13'd1, 13'd1, 0, 40);
    // Largest regular image, with lines along its far edge.
    run_phase(45, 13'd4096, 13'd4096, 30, 0);
    queue_line(make_line(4096 * PIX_SPAN - 2000, 100 * PIX_SPAN,
                         4096 * PIX_SPAN + 2000, 4095 * PIX_SPAN + 900));
    queue_line(make_line(200, 4096 * PIX_SPAN + 1500, 900, 4096 * PIX_SPAN - 1500));
    // A zero width hides every point; the tallest height is used as written.
    run_phase(35, 13'd0, 13'd8191, 10, 10);
    // Oversized width: visible pixels past 4095 show only their low bits.
    run_phase(35, 13'd8191, 13'd4096, 15, 30);
    queue_line(make_line(4195000, 1000, 4195000 + 20000, 1000 + 3000));
    // An arbitrary image size.
    run_phase(50, 13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)), 25, 25);
    // Last stretch: a common screen size, with both sides running flat out.
    run_phase(55, 13'd640, 13'd480, 0, 0);

    wait_idle();
    $display("Walked %0d line requests into %0d checked pixels over %0d image sizes.",
             lines_taken, pixels_seen, settings_seen);
    $display("%0d lines hit the point cap, %0d were zero length, %0d mismatches seen.",
             capped_lines, zero_lines, fails);
    if (fails == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/dlps_pkg.sv
hw/rtl/dlps_if.sv
hw/rtl/dlps_ctrl.sv
hw/rtl/dlps_dp.sv
hw/rtl/dda_line_pixel_stepper_unit.sv
dv/dda_line_pixel_stepper_unit_tb.sv
